### rtl/dtsi_pkg.sv
// ----------------------------------------------------------------------------
// dtsi_pkg
// Types and character codes shared by the decimal text parser.
// ----------------------------------------------------------------------------
package dtsi_pkg;

  localparam int MAG_W   = 63;
  localparam int SCALE_W = 16;
  localparam int MANT_W  = 64;
  // magnitude times ten plus a digit needs four more bits than the magnitude
  localparam int PROD_W  = MAG_W + 4;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [SCALE_W-1:0] SCALE_MAX = '1;

  typedef struct packed {
    logic               at_first_char;
    logic               is_negative;
    logic               dot_seen;
    logic               any_digit_seen;
    logic               nonfraction_digit_seen;
    logic               has_failed;
    logic [MAG_W-1:0]   magnitude_acc;
    // magnitude_acc times ten to the pending zeros, with a flag for overflow
    logic [MAG_W-1:0]   scaled_acc;
    logic               scaled_big;
    logic [SCALE_W-1:0] committed_scale;
    logic [SCALE_W-1:0] pending_zeros;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    at_first_char:          1'b1,
    is_negative:            1'b0,
    dot_seen:               1'b0,
    any_digit_seen:         1'b0,
    nonfraction_digit_seen: 1'b0,
    has_failed:             1'b0,
    magnitude_acc:          '0,
    scaled_acc:             '0,
    scaled_big:             1'b0,
    committed_scale:        '0,
    pending_zeros:          '0
  };

  typedef struct packed {
    logic                     parse_ok;
    logic signed [MANT_W-1:0] signed_mantissa;
    logic [SCALE_W-1:0]       decimal_scale;
  } parse_result_t;

endpackage

### rtl/dtsi_step.sv
// ----------------------------------------------------------------------------
// dtsi_step
// Next parser state and end-of-text result for one character item.
// ----------------------------------------------------------------------------
module dtsi_step import dtsi_pkg::*; (
  input  parse_state_t  cur,
  input  logic [7:0]    char_code,
  input  logic          has_char,
  input  logic          last_char,
  output parse_state_t  nxt,
  output parse_result_t res
);

  logic [PROD_W-1:0]  prod;
  logic               prod_ovf;
  logic [SCALE_W:0]   scale_sum;
  logic [3:0]         digit;
  logic               is_digit;
  logic [MANT_W-1:0]  mag_ext;
  parse_state_t       upd;

  // scaled_acc * 10 + digit, by shift and add
  assign digit     = char_code[3:0];
  assign prod      = ({4'b0, cur.scaled_acc} << 3) + ({4'b0, cur.scaled_acc} << 1)
                     + PROD_W'(digit);
  assign prod_ovf  = cur.scaled_big | (prod[PROD_W-1:MAG_W] != '0);
  assign scale_sum = {1'b0, cur.committed_scale} + {1'b0, cur.pending_zeros}
                     + (SCALE_W+1)'(1);

  always_comb begin
    is_digit = char_code inside {[CH_0:CH_9]};
    upd      = cur;
    if (has_char) begin
      upd.at_first_char = 1'b0;
      if (!cur.has_failed) begin
        if ((char_code == CH_PLUS || char_code == CH_MINUS) && cur.at_first_char) begin
          upd.is_negative = (char_code == CH_MINUS);
        end else if (char_code == CH_DOT) begin
          if (cur.dot_seen) upd.has_failed = 1'b1;
          else upd.dot_seen = 1'b1;
        end else if (is_digit) begin
          upd.any_digit_seen = 1'b1;
          if (!cur.dot_seen) begin
            upd.nonfraction_digit_seen = 1'b1;
            if (prod_ovf) begin
              upd.has_failed = 1'b1;
            end else begin
              upd.magnitude_acc = prod[MAG_W-1:0];
              upd.scaled_acc    = prod[MAG_W-1:0];
            end
          end else if (digit == 4'd0) begin
            // hold the zero pending; drop it once the counter saturates
            if (cur.pending_zeros != SCALE_MAX) begin
              upd.pending_zeros = cur.pending_zeros + SCALE_W'(1);
              upd.scaled_acc    = prod[MAG_W-1:0];
              upd.scaled_big    = prod_ovf;
            end
          end else if (scale_sum[SCALE_W] || prod_ovf) begin
            upd.has_failed = 1'b1;
          end else begin
            upd.magnitude_acc   = prod[MAG_W-1:0];
            upd.scaled_acc      = prod[MAG_W-1:0];
            upd.scaled_big      = 1'b0;
            upd.committed_scale = scale_sum[SCALE_W-1:0];
            upd.pending_zeros   = '0;
          end
        end else begin
          upd.has_failed = 1'b1;
        end
      end
    end

    mag_ext = {1'b0, upd.magnitude_acc};
    res.parse_ok = !upd.has_failed && upd.any_digit_seen &&
                   (upd.nonfraction_digit_seen || upd.committed_scale != '0);
    if (res.parse_ok) begin
      res.signed_mantissa = upd.is_negative ? -mag_ext : mag_ext;
      res.decimal_scale   = upd.committed_scale;
    end else begin
      res.signed_mantissa = '0;
      res.decimal_scale   = '0;
    end

    nxt = last_char ? STATE_RESET : upd;
  end

endmodule

### rtl/decimal_text_to_scaled_integer.sv
// ----------------------------------------------------------------------------
// decimal_text_to_scaled_integer
// Streaming parser of decimal text into a signed mantissa and a decimal scale.
// ----------------------------------------------------------------------------
// A last item's result is registered onto the output when it leaves the input register.
// Throughput: one item per cycle while in_stall is low; the state update is a shift-add
// by ten and a compare in combinational logic between the input and state registers.
// The input stage stalls only when a last item meets a stalled, full output.
// Reset clears the parser state and all valid flags; no clearing pass.
module decimal_text_to_scaled_integer import dtsi_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               char_code,
  input  logic                     has_char,
  input  logic                     last_char,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     parse_ok,
  output logic signed [MANT_W-1:0] signed_mantissa,
  output logic [SCALE_W-1:0]       decimal_scale
);

  logic          held_valid;
  logic [7:0]    held_char;
  logic          held_has;
  logic          held_last;
  logic          advance;
  parse_state_t  state;
  parse_state_t  state_next;
  parse_result_t result_next;

  dtsi_step u_step (
    .cur       (state),
    .char_code (held_char),
    .has_char  (held_has),
    .last_char (held_last),
    .nxt       (state_next),
    .res       (result_next)
  );

  // advance the held item unless its result has nowhere to go
  assign advance  = held_valid && !(held_last && out_valid && out_stall);
  assign in_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_char <= char_code;
      held_has  <= has_char;
      held_last <= last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && held_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_last) begin
      parse_ok        <= result_next.parse_ok;
      signed_mantissa <= result_next.signed_mantissa;
      decimal_scale   <= result_next.decimal_scale;
    end
  end

endmodule
